FILE: rtl/nsd_pkg.sv
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types and constants for the netstring deframer.
// ----------------------------------------------------------------------------
package nsd_pkg;

  // Width of the length accumulator and payload counter (8 to 32)
  localparam int LEN_WIDTH = 24;
  // Width of the maximum-payload register
  localparam int CFG_WIDTH = 24;
  // Common width for comparing length against the limit
  localparam int CMP_WIDTH = 33;
  // Width of the length times ten plus a digit
  localparam int WIDE_WIDTH = LEN_WIDTH + 4;

  localparam logic [LEN_WIDTH-1:0] LEN_SAT   = '1;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = '1;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_DATA  = 2'd1,
    PH_COMMA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // One result beat from the parser
  typedef struct packed {
    logic       hit;
    kind_t      kind;
    logic [7:0] data;
  } nsd_result_t;

endpackage

FILE: rtl/nsd_parser.sv
// ----------------------------------------------------------------------------
// nsd_parser
// Frame state and the per-byte parse step; gives at most one result per byte.
// ----------------------------------------------------------------------------
module nsd_parser
  import nsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_WIDTH-1:0] cfg_wr_data,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  output nsd_result_t          result
);

  phase_t               phase, phase_next;
  logic [LEN_WIDTH-1:0] length_accum, length_accum_next;
  logic                 digit_seen, digit_seen_next;
  logic [LEN_WIDTH-1:0] bytes_left, bytes_left_next;
  logic [CFG_WIDTH-1:0] max_payload;

  logic                  is_digit;
  logic [WIDE_WIDTH-1:0] accum_wide;
  logic [WIDE_WIDTH-1:0] accum_times_ten;
  logic [LEN_WIDTH-1:0]  accum_step;
  logic                  len_ok;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= CFG_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  // Decimal accumulate with saturation
  assign is_digit        = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign accum_wide      = {4'd0, length_accum};
  assign accum_times_ten = (accum_wide << 3) + (accum_wide << 1)
                         + {{(WIDE_WIDTH-4){1'b0}}, byte_in[3:0]};
  assign accum_step      = ((length_accum == LEN_SAT) ||
                            (accum_times_ten >= {4'd0, LEN_SAT}))
                         ? LEN_SAT : accum_times_ten[LEN_WIDTH-1:0];

  // Declared length within range at the colon
  assign len_ok = (length_accum != LEN_SAT) &&
                  ({{(CMP_WIDTH-LEN_WIDTH){1'b0}}, length_accum} <=
                   {{(CMP_WIDTH-CFG_WIDTH){1'b0}}, max_payload});

  // Next state and result
  always_comb begin
    phase_next        = phase;
    length_accum_next = length_accum;
    digit_seen_next   = digit_seen;
    bytes_left_next   = bytes_left;
    result            = '{hit: 1'b0, kind: KIND_DATA, data: 8'd0};
    unique case (phase)
      PH_DATA: begin
        bytes_left_next = bytes_left - 1'b1;
        if (bytes_left_next == '0) begin
          phase_next = PH_COMMA;
        end
        result = '{hit: 1'b1, kind: KIND_DATA, data: byte_in};
      end
      PH_COMMA: begin
        phase_next        = PH_LEN;
        length_accum_next = '0;
        digit_seen_next   = 1'b0;
        bytes_left_next   = '0;
        if (byte_in != CH_COMMA) begin
          result = '{hit: 1'b1, kind: KIND_ERR, data: 8'd0};
        end else if (length_accum != '0) begin
          result = '{hit: 1'b1, kind: KIND_GOOD, data: 8'd0};
        end
      end
      default: begin
        // length digits; the unused code lands here as well
        if (is_digit) begin
          length_accum_next = accum_step;
          digit_seen_next   = 1'b1;
          phase_next        = PH_LEN;
        end else if ((byte_in == CH_COLON) && digit_seen && len_ok) begin
          bytes_left_next = length_accum;
          digit_seen_next = 1'b0;
          phase_next      = (length_accum == '0) ? PH_COMMA : PH_DATA;
        end else begin
          phase_next        = PH_LEN;
          length_accum_next = '0;
          digit_seen_next   = 1'b0;
          bytes_left_next   = '0;
          result = '{hit: 1'b1, kind: KIND_ERR, data: 8'd0};
        end
      end
    endcase
    if (!step) begin
      result.hit = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEN;
      length_accum <= '0;
      digit_seen   <= 1'b0;
      bytes_left   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      length_accum <= length_accum_next;
      digit_seen   <= digit_seen_next;
      bytes_left   <= bytes_left_next;
    end
  end

  // A payload phase always has bytes outstanding
  a_data_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_left != '0))
    else $error("payload phase with no bytes left");

  // Digit flag is only live while parsing the length
  a_digit_phase: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_LEN) |-> !digit_seen)
    else $error("digit flag set outside length phase");

endmodule

FILE: rtl/nsd_out_reg.sv
// ----------------------------------------------------------------------------
// nsd_out_reg
// Result register towards the consumer; reports when it can take a beat.
// ----------------------------------------------------------------------------
module nsd_out_reg
  import nsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  nsd_result_t result,
  output logic        free,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte
);

  logic res_valid_next;

  // Register is free when empty or being drained this cycle
  assign free = !res_valid || !res_stall;

  always_comb begin
    res_valid_next = res_valid;
    if (free) begin
      res_valid_next = result.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (free && result.hit) begin
      kind      <= result.kind;
      data_byte <= result.data;
    end
  end

  // Only payload beats carry data
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (kind != KIND_DATA)) |-> (data_byte == 8'd0))
    else $error("non-payload beat with data");

  // Kind code is always a defined one
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((kind == KIND_DATA) || (kind == KIND_GOOD) || (kind == KIND_ERR)))
    else $error("undefined result kind");

endmodule

FILE: rtl/netstring_deframer.sv
// ----------------------------------------------------------------------------
// netstring_deframer
// Byte-serial netstring deframer: length digits, colon, payload, comma.
// ----------------------------------------------------------------------------
//  channel | signals                                | direction
//  rx      | rx_valid, rx_stall, rx_byte            | in, one byte per beat
//  res     | res_valid, res_stall, kind, data_byte  | out, at most one per byte
//  cfg     | cfg_wr_en, cfg_wr_data                 | in, max payload length
//
// One byte per cycle sustained unless res stalls. A byte is held in the input
// register, is parsed in one step and its result is registered in the result
// register. Synchronous active-high reset returns the parser to length
// parsing and the limit to all ones.
// A stall on res holds the result register and, through it, the input
// register; rx_stall rises only while a parsed byte waits on a full result.
// ----------------------------------------------------------------------------
module netstring_deframer
  import nsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  logic [7:0]           rx_byte,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [1:0]           kind,
  output logic [7:0]           data_byte,
  input  logic                 cfg_wr_en,
  input  logic [CFG_WIDTH-1:0] cfg_wr_data
);

  logic        in_valid, in_valid_next;
  logic [7:0]  in_byte;
  logic        free;
  logic        step;
  logic        rx_take;
  nsd_result_t result;

  assign step     = in_valid && free;
  assign rx_stall = in_valid && !free;
  assign rx_take  = rx_valid && !rx_stall;

  // Input register
  always_comb begin
    in_valid_next = in_valid;
    if (rx_take) begin
      in_valid_next = 1'b1;
    end else if (step) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      in_byte <= rx_byte;
    end
  end

  // Parse step
  nsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .byte_in     (in_byte),
    .result      (result)
  );

  // Result register
  nsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .free      (free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .kind      (kind),
    .data_byte (data_byte)
  );

  // Stall only with a byte waiting in the input register
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> in_valid)
    else $error("input stalled with nothing pending");

endmodule

FILE: verif/nsd_checker.sv
// ----------------------------------------------------------------------------
// nsd_checker
// Watches the byte and result channels of the netstring deframer. Keeps its
// own copy of the parser state and the length limit, predicts the result of
// every accepted byte and compares each result beat, field by field, with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module nsd_checker
  import nsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  input  logic                 rx_stall,
  input  logic [7:0]           rx_byte,
  input  logic                 res_valid,
  input  logic                 res_stall,
  input  logic [1:0]           kind,
  input  logic [7:0]           data_byte,
  input  logic                 cfg_wr_en,
  input  logic [CFG_WIDTH-1:0] cfg_wr_data,
  output int                   fail_count,
  output int                   backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTS = 40;
  localparam int DEC_BASE   = 10;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } frame_beat_t;

  // Parser copy
  phase_t               ph;
  logic [LEN_WIDTH-1:0] len_acc;
  logic [LEN_WIDTH-1:0] left;
  logic                 seen;
  logic [CFG_WIDTH-1:0] limit;

  frame_beat_t deframed_q[$];
  frame_beat_t want;
  int          mismatch_count = 0;

  assign fail_count = mismatch_count;

  task automatic report(input string msg);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t nsd_checker: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void clear_frame();
    ph      = PH_LEN;
    len_acc = '0;
    left    = '0;
    seen    = 1'b0;
  endfunction

  function automatic void queue_result(input kind_t k, input logic [7:0] d);
    frame_beat_t b;
    b.kind = k;
    b.data = d;
    deframed_q.push_back(b);
  endfunction

  // One received byte through the parser
  task automatic deframe_byte(input logic [7:0] b);
    logic [WIDE_WIDTH-1:0] grown;
    logic                  was_empty;
    case (ph)
      PH_DATA: begin
        left = left - 1'b1;
        if (left == '0) ph = PH_COMMA;
        queue_result(KIND_DATA, b);
      end
      PH_COMMA: begin
        // length is still held here, so an empty frame is told apart
        was_empty = (len_acc == '0);
        clear_frame();
        if (b != CH_COMMA)
          queue_result(KIND_ERR, 8'h00);
        else if (!was_empty)
          queue_result(KIND_GOOD, 8'h00);
      end
      default: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          // decimal accumulate, saturating at all ones
          grown = WIDE_WIDTH'(WIDE_WIDTH'(len_acc) * DEC_BASE +
                              WIDE_WIDTH'(b - CH_ZERO));
          if (len_acc == LEN_SAT || grown >= WIDE_WIDTH'(LEN_SAT))
            len_acc = LEN_SAT;
          else
            len_acc = grown[LEN_WIDTH-1:0];
          seen = 1'b1;
          ph   = PH_LEN;
        end else if (b == CH_COLON && seen && len_acc != LEN_SAT &&
                     CMP_WIDTH'(len_acc) <= CMP_WIDTH'(limit)) begin
          left = len_acc;
          seen = 1'b0;
          ph   = (len_acc == '0) ? PH_COMMA : PH_DATA;
        end else begin
          // stray byte, bare colon or length over the limit
          clear_frame();
          queue_result(KIND_ERR, 8'h00);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      limit = CFG_RESET;
      clear_frame();
      deframed_q.delete();
    end else begin
      // result beat against the oldest prediction
      if (res_valid && !res_stall) begin
        if (deframed_q.size() == 0) begin
          report($sformatf("result beat kind %0d data %02h with nothing predicted",
                           kind, data_byte));
        end else begin
          want = deframed_q.pop_front();
          if (kind !== want.kind)
            report($sformatf("kind %0d, predicted %0d", kind, want.kind));
          if (data_byte !== want.data)
            report($sformatf("data_byte %02h, predicted %02h", data_byte, want.data));
        end
      end
      if (cfg_wr_en) limit = cfg_wr_data;
      if (rx_valid && !rx_stall) deframe_byte(rx_byte);
    end
    backlog <= deframed_q.size();
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the netstring deframer. Feeds a short directed stream of
// frames and faults, then mostly well-formed random frames mixed with broken
// ones, under several length limits including both extremes. Both channels
// idle in random bursts; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nsd_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE_WAIT = 6;

  logic                 clk;
  logic                 rst;
  logic                 rx_valid;
  logic                 rx_stall;
  logic [7:0]           rx_byte;
  logic                 res_valid;
  logic                 res_stall;
  logic [1:0]           kind;
  logic [7:0]           data_byte;
  logic                 cfg_wr_en;
  logic [CFG_WIDTH-1:0] cfg_wr_data;

  int                   fail_count;
  int                   backlog;
  int                   bytes_sent = 0;
  int                   still_cycles = 0;
  bit                   quiet = 1'b0;
  logic [CFG_WIDTH-1:0] limit_now = CFG_RESET;

  netstring_deframer u_dut (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .kind        (kind),
    .data_byte   (data_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  nsd_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .kind        (kind),
    .data_byte   (data_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .backlog     (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side stalls in random bursts
  initial begin
    int burst;
    burst = 0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (burst > 0) begin
        burst--;
        res_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 3);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall) || cfg_wr_en) begin
      still_cycles <= 0;
    end else if (still_cycles == IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      still_cycles <= still_cycles + 1;
    end
  end

  // One byte beat, with an optional gap in front
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Netstring frame with random payload; optionally the comma is replaced
  task automatic send_frame(input bit drop_comma);
    int unsigned len;
    logic [7:0]  tail;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    if ($urandom_range(0, 4) == 0) send_byte(CH_ZERO);
    send_text($sformatf("%0d:", len));
    for (int unsigned k = 0; k < len; k++) send_byte(8'($urandom));
    tail = CH_COMMA;
    if (drop_comma) begin
      tail = 8'($urandom);
      if (tail == CH_COMMA) tail = ~tail;
    end
    send_byte(tail);
  endtask

  // Random stream until n more bytes have gone in
  task automatic random_bytes(input int n);
    int              stop;
    int unsigned     pick;
    logic [7:0]      b;
    longint unsigned big;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(1'b0);
      end else if (pick < 78) begin
        send_frame(1'b1);
      end else if (pick < 84) begin
        // stray byte among the length digits
        send_text($sformatf("%0d", $urandom_range(0, 99)));
        do b = 8'($urandom);
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON);
        send_byte(b);
      end else if (pick < 88) begin
        send_byte(CH_COLON);
      end else if (pick < 94) begin
        // declared length over the limit, or saturating
        if (limit_now >= CFG_RESET - 1 || $urandom_range(0, 3) == 0)
          big = 64'd16777215 + $urandom_range(0, 9999999);
        else
          big = limit_now + 1 + $urandom_range(0, 2);
        send_text($sformatf("%0d:", big));
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  // Let the block drain, then write the length limit
  task automatic set_limit(input logic [CFG_WIDTH-1:0] v);
    rx_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_now = v;
  endtask

  initial begin
    rst         <= 1'b1;
    rx_valid    <= 1'b0;
    rx_byte     <= 8'h00;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty frame, extreme payload bytes, each fault kind
    send_text("0:,");
    send_text("2:");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(CH_COMMA);
    send_text("a");
    send_text(":");
    send_text("0:x");
    send_text("1:qx");
    send_text("16777215:");

    random_bytes(230);
    set_limit('0);
    random_bytes(120);
    set_limit(CFG_WIDTH'($urandom_range(1, 12)));
    random_bytes(200);
    set_limit(CFG_WIDTH'($urandom_range(13, 1 << 20)));
    random_bytes(150);
    set_limit(CFG_RESET);
    quiet = 1'b1;
    random_bytes(180);

    // Drain and verdict
    rx_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && backlog == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
